[src/assert_macros.svh]
// Assertion macros shared by the array set table RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, ignored while reset is low.
`define AST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at each rising clock edge, reset included.
`define AST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[src/ast_pkg.sv]
// Shared types and constants for the array set table.
// No dependencies.
package ast_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int POS_W    = 7;
    localparam int OCC_W    = 8;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_SEARCH = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    localparam logic [2:0] STAT_INSERTED = 3'd0;
    localparam logic [2:0] STAT_PRESENT  = 3'd1;
    localparam logic [2:0] STAT_FULL     = 3'd2;
    localparam logic [2:0] STAT_FOUND    = 3'd3;
    localparam logic [2:0] STAT_ABSENT   = 3'd4;
    localparam logic [2:0] STAT_REMOVED  = 3'd5;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [DATA_W-1:0] element;
    } t_in;

    typedef struct packed {
        logic [2:0]       status;
        logic [POS_W-1:0] position;
        logic [OCC_W-1:0] occupancy;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        POS_ZERO,
        POS_HIT,
        POS_COUNT
    } t_pos_sel;

    // Controller to datapath
    typedef struct packed {
        logic       load;       // capture request, restart the walk
        logic       walk;       // issue next entry read
        logic       shift;      // write each returned entry one place down
        logic       ins;        // append value at the count, bump count
        logic       dec;        // drop count by one
        logic       res_load;   // latch result status and position
        logic [2:0] res_status;
        t_pos_sel   pos_sel;
        logic       publish;    // move result to the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic hit;       // returned entry matches the value
        logic walk_end;  // every valid entry has been returned
        logic full;      // count has reached capacity
    } t_sts;

endpackage

[src/ast_dp.sv]
// Datapath of the array set table: entry memory, count, walk pointer, result.
// Depends on ast_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ast_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ast_pkg::t_in  i_req,
    input  ast_pkg::t_cmd i_cmd,
    output ast_pkg::t_sts o_sts,
    output ast_pkg::t_out o_out
);
    import ast_pkg::*;

    logic [DATA_W-1:0] r_mem [CAPACITY];
    logic [DATA_W-1:0] r_rd_data;
    logic [DATA_W-1:0] r_value;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_ptr;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [2:0]        r_status;
    logic [IDX_W-1:0]  r_pos;
    t_out              r_out;

    logic              issue;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;

    always_comb begin
        issue   = i_cmd.walk && (r_ptr < r_count);
        rd_addr = r_ptr[IDX_W-1:0];
        wr_en   = i_cmd.ins || (i_cmd.shift && r_rd_vld);
        wr_addr = i_cmd.ins ? r_count[IDX_W-1:0] : (r_rd_idx - 1'b1);
        wr_data = i_cmd.ins ? r_value : r_rd_data;
    end

    always_comb begin
        o_sts.hit      = r_rd_vld && (r_rd_data == r_value);
        o_sts.walk_end = !r_rd_vld && (r_ptr >= r_count);
        o_sts.full     = (r_count >= CNT_W'(CAPACITY));
    end

    // single write port, single registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_ptr    <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.walk) begin
                r_rd_vld <= issue;
                if (issue) begin
                    r_ptr <= r_ptr + 1'b1;
                end
            end
            if (i_cmd.ins) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.dec) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_req.element;
        end
        if (issue) begin
            r_rd_idx <= rd_addr;
        end
        if (i_cmd.res_load) begin
            r_status <= i_cmd.res_status;
            case (i_cmd.pos_sel)
                POS_HIT:   r_pos <= r_rd_idx;
                POS_COUNT: r_pos <= r_count[IDX_W-1:0];
                default:   r_pos <= '0;
            endcase
        end
        if (i_cmd.publish) begin
            r_out.status    <= r_status;
            r_out.position  <= POS_W'(r_pos);
            r_out.occupancy <= OCC_W'(r_count);
        end
    end

    assign o_out = r_out;

    `AST_ASSERT(a_count_max, r_count <= CNT_W'(CAPACITY), "entry count above capacity")
    `AST_ASSERT(a_shift_idx, (i_cmd.shift && r_rd_vld) |-> (r_rd_idx != '0), "shift write below entry 0")
    `AST_ASSERT(a_ins_count, i_cmd.ins |=> (r_count == $past(r_count) + 1'b1), "insert lost count")

endmodule

[src/ast_ctrl.sv]
// Controller state machine of the array set table: handshakes and datapath commands.
// Depends on ast_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ast_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_action,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  ast_pkg::t_sts i_sts,
    output ast_pkg::t_cmd o_cmd
);
    import ast_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_action;
    logic       r_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_action) inside
                        ACT_INSERT:             n_state = i_sts.full ? ST_DONE : ST_SCAN;
                        ACT_SEARCH, ACT_REMOVE: n_state = ST_SCAN;
                        default:                n_state = ST_DONE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (i_sts.hit) begin
                    n_state = (r_action == ACT_REMOVE) ? ST_SHIFT : ST_DONE;
                end else if (i_sts.walk_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_SHIFT: begin
                if (i_sts.walk_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.pos_sel = POS_ZERO;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_action) inside
                        ACT_INSERT: begin
                            if (i_sts.full) begin
                                o_cmd.res_load   = 1'b1;
                                o_cmd.res_status = STAT_FULL;
                            end else begin
                                o_cmd.load = 1'b1;
                            end
                        end
                        ACT_SEARCH, ACT_REMOVE: o_cmd.load = 1'b1;
                        default: begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = STAT_ABSENT;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.walk = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.pos_sel  = POS_HIT;
                    case (r_action)
                        ACT_INSERT: o_cmd.res_status = STAT_PRESENT;
                        ACT_SEARCH: o_cmd.res_status = STAT_FOUND;
                        default:    o_cmd.res_status = STAT_REMOVED;
                    endcase
                end else if (i_sts.walk_end) begin
                    o_cmd.res_load = 1'b1;
                    if (r_action == ACT_INSERT) begin
                        o_cmd.ins        = 1'b1;
                        o_cmd.res_status = STAT_INSERTED;
                        o_cmd.pos_sel    = POS_COUNT;
                    end else begin
                        o_cmd.res_status = STAT_ABSENT;
                    end
                end
            end
            ST_SHIFT: begin
                o_cmd.walk  = 1'b1;
                o_cmd.shift = 1'b1;
                o_cmd.dec   = i_sts.walk_end;
            end
            ST_DONE: begin
                o_cmd.publish = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_action <= i_action;
        end
    end

    assign o_out_valid = r_out_valid;

    `AST_ASSERT(a_publish_valid, o_cmd.publish |=> r_out_valid, "published result not valid")
    `AST_ASSERT(a_remove_shift, (r_state == ST_SCAN && i_sts.hit && r_action == ACT_REMOVE) |=> (r_state == ST_SHIFT), "found remove skipped compaction")

endmodule

[src/array_set_table.sv]
// Top level of the array set table: ties the controller to the datapath.
// Depends on ast_pkg, ast_ctrl and ast_dp.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in  (action, element)
//  out     | output    | o_out_valid / i_out_ready  | o_out (status, position, occupancy)
//
// One request at a time, walked one entry per cycle through the single registered read
// port. Reset is synchronous and clears the count and control only; the entries need no
// clearing pass. A stalled output holds its result while the next request is walked.
module array_set_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ast_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ast_pkg::t_out o_out
);
    import ast_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequence each request: accept, scan, optional compaction, then transfer out.
    ast_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_in.action),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Hold the entries and count, compare each returned entry, build the result.
    ast_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_out   (o_out)
    );

endmodule

[tb/tb_array_set_table.sv]
// Self-checking testbench for array_set_table: predicts each request's status, position
// and occupancy from a local copy of the table and checks every output transfer.
// Depends on ast_pkg and the array_set_table RTL.
`timescale 1ns / 100ps

module tb_array_set_table;

    import ast_pkg::*;

    localparam int CLK_HALF_NS   = 4;
    localparam int RESET_CYCLES  = 8;
    localparam int IDLE_PCT      = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int POOL_SIZE     = 32;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int QUIET_ITEMS   = 200;
    localparam int PRESSURE_REQS = 8;
    localparam int SETTLE_CYCLES = 2 * CAPACITY + 16;
    localparam int RUN_LIMIT_NS  = 20_000_000;
    localparam int MAX_REPORTS   = 40;

    // Action code the block leaves unused; it must behave as a no-op.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value.
    // ------------------------------------------------------------------
    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  i_in_valid  = 1'b0;
    logic  o_in_ready;
    t_in   i_in        = '0;
    logic  o_out_valid;
    logic  i_out_ready = 1'b0;
    t_out  o_out;

    array_set_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow copy of the table, advanced once per accepted request.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] tbl_entries [CAPACITY];
    int                tbl_count = 0;

    t_out              pending_results [$];
    logic [DATA_W-1:0] value_pool [POOL_SIZE];

    int n_errors  = 0;
    int n_sent    = 0;
    int n_checked = 0;
    int status_tally [6] = '{default: 0};

    // Idle rates, changed by the tests to open and close no-idle stretches.
    int send_idle_pct = IDLE_PCT;
    int recv_idle_pct = IDLE_PCT;

    // Hold-off request: the test bumps hold_req_seq, the receiver alone acks it.
    int hold_req_seq = 0;
    int hold_ack_seq = 0;
    int hold_left    = 0;

    // Linear search over the valid shadow entries; -1 when absent.
    function automatic int find_entry(input logic [DATA_W-1:0] value);
        for (int k = 0; k < tbl_count; k++) begin
            if (tbl_entries[k] == value) begin
                return k;
            end
        end
        return -1;
    endfunction

    // Apply one request to the shadow table and return the result it must produce.
    function automatic t_out predict_table_op(input t_in req);
        t_out res;
        int   hit;
        res.status   = STAT_ABSENT;
        res.position = '0;
        hit          = find_entry(req.element);
        case (req.action)
            ACT_INSERT: begin
                // Fullness wins over a duplicate.
                if (tbl_count >= CAPACITY) begin
                    res.status = STAT_FULL;
                end else if (hit >= 0) begin
                    res.status   = STAT_PRESENT;
                    res.position = hit[POS_W-1:0];
                end else begin
                    res.status   = STAT_INSERTED;
                    res.position = tbl_count[POS_W-1:0];
                    tbl_entries[tbl_count] = req.element;
                    tbl_count++;
                end
            end
            ACT_SEARCH: begin
                if (hit >= 0) begin
                    res.status   = STAT_FOUND;
                    res.position = hit[POS_W-1:0];
                end
            end
            ACT_REMOVE: begin
                if (hit >= 0) begin
                    res.status   = STAT_REMOVED;
                    res.position = hit[POS_W-1:0];
                    // Close the gap, keeping the order of later entries.
                    for (int j = hit; j + 1 < tbl_count; j++) begin
                        tbl_entries[j] = tbl_entries[j + 1];
                    end
                    tbl_count--;
                end
            end
            default: ;
        endcase
        res.occupancy = tbl_count[OCC_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned exp_v,
                                   input logic [7:0] got_v);
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
        end
    endtask

    // ------------------------------------------------------------------
    // Scoreboard: check the output transfer first, then queue the
    // prediction for a request accepted at the same edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out want;
        t_out got;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = o_out;
                if (pending_results.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS) begin
                        $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                                 $time, got.status, got.position, got.occupancy);
                    end
                end else begin
                    want = pending_results.pop_front();
                    n_checked++;
                    if (got.status !== want.status) begin
                        report_mismatch("status", want.status, got.status);
                    end
                    if (got.position !== want.position) begin
                        report_mismatch("position", want.position, got.position);
                    end
                    if (got.occupancy !== want.occupancy) begin
                        report_mismatch("occupancy", want.occupancy, got.occupancy);
                    end
                    if (got.status <= STAT_REMOVED) begin
                        status_tally[got.status]++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                pending_results.push_back(predict_table_op(i_in));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random ready, with a counted hold-off on request.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_req_seq != hold_ack_seq) begin
            hold_ack_seq = hold_req_seq;
            hold_left    = HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sender: insert random gaps, then hold valid and payload until the
    // transfer. Valid is left high so back-to-back requests need no drop.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [1:0] act, input logic [DATA_W-1:0] value);
        t_in req;
        req.action  = act;
        req.element = value;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
    endtask

    // Drop valid and pause until every predicted result has arrived. Wait on a
    // clock edge first so the scoreboard has queued the last accepted request.
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Random request biased toward hits: elements come from the live table,
    // a small pool of recurring values, or fresh 32-bit patterns.
    task automatic send_random_request();
        int                r;
        int                ins_w;
        int                src;
        logic [1:0]        act;
        logic [DATA_W-1:0] value;
        r     = $urandom_range(99);
        // Steer occupancy away from both ends.
        ins_w = (tbl_count < 8) ? 60 : ((tbl_count > 96) ? 15 : 40);
        if (r < ins_w) begin
            act = ACT_INSERT;
        end else if (r >= 96) begin
            act = ACT_UNUSED;
        end else if (r < ins_w + (96 - ins_w) / 2) begin
            act = ACT_SEARCH;
        end else begin
            act = ACT_REMOVE;
        end
        src = $urandom_range(99);
        if (src < 45 && tbl_count > 0) begin
            value = tbl_entries[$urandom_range(tbl_count - 1)];
        end else if (src < 85) begin
            value = value_pool[$urandom_range(POOL_SIZE - 1)];
        end else begin
            value = $urandom;
        end
        send_request(act, value);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty table, extreme values, every action, duplicates and shift-down.
    task automatic test_empty_and_edges();
        send_request(ACT_SEARCH, 32'h0000_0000);   // absent on an empty table
        send_request(ACT_REMOVE, 32'hFFFF_FFFF);   // nothing to remove
        send_request(ACT_UNUSED, 32'h5A5A_A5A5);   // unused code, empty table
        send_request(ACT_INSERT, 32'h8000_0000);
        send_request(ACT_INSERT, 32'h7FFF_FFFF);
        send_request(ACT_INSERT, 32'hFFFF_FFFF);
        send_request(ACT_INSERT, 32'h0000_0000);
        send_request(ACT_INSERT, 32'h7FFF_FFFF);   // duplicate keeps its slot
        send_request(ACT_SEARCH, 32'hFFFF_FFFF);
        send_request(ACT_SEARCH, 32'h8000_0000);
        send_request(ACT_SEARCH, 32'h0000_0001);
        send_request(ACT_UNUSED, 32'h0000_0000);   // unused code on a held value
        send_request(ACT_REMOVE, 32'h7FFF_FFFF);   // later entries move down
        send_request(ACT_SEARCH, 32'hFFFF_FFFF);
        send_request(ACT_REMOVE, 32'h0000_0000);   // last entry, no shift
        send_request(ACT_REMOVE, 32'h0000_0000);   // already gone
        send_request(ACT_REMOVE, 32'h8000_0000);
        send_request(ACT_REMOVE, 32'hFFFF_FFFF);
        send_request(ACT_SEARCH, 32'hFFFF_FFFF);
        wait_results_drained();
    endtask

    // Fill to capacity, insert into a full table (held value too), remove
    // the head for the longest shift, then empty it in random order.
    task automatic test_fill_to_capacity();
        logic [DATA_W-1:0] vals [CAPACITY];
        logic [DATA_W-1:0] tmp;
        int                j;
        // Low bits carry the index so every value is distinct.
        for (int i = 0; i < CAPACITY; i++) begin
            vals[i]            = $urandom;
            vals[i][IDX_W-1:0] = i[IDX_W-1:0];
        end
        for (int i = 0; i < CAPACITY; i++) begin
            send_request(ACT_INSERT, vals[i]);
        end
        send_request(ACT_INSERT, vals[CAPACITY / 2]);
        send_request(ACT_INSERT, $urandom);
        send_request(ACT_SEARCH, vals[0]);
        send_request(ACT_SEARCH, vals[CAPACITY - 1]);
        send_request(ACT_REMOVE, vals[0]);
        send_request(ACT_INSERT, vals[0]);
        send_request(ACT_REMOVE, vals[CAPACITY - 1]);
        for (int i = CAPACITY - 1; i > 0; i--) begin
            j       = $urandom_range(i);
            tmp     = vals[i];
            vals[i] = vals[j];
            vals[j] = tmp;
        end
        for (int i = 0; i < CAPACITY; i++) begin
            send_request(ACT_REMOVE, vals[i]);
        end
        send_request(ACT_SEARCH, vals[0]);
        wait_results_drained();
    endtask

    // Long random mix; the opening stretch runs with no idling on either side.
    task automatic test_random_requests();
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'hFFFF_FFFF;
        value_pool[3] = 32'h0000_0000;
        for (int i = 4; i < POOL_SIZE; i++) begin
            value_pool[i] = $urandom;
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == QUIET_ITEMS) begin
                send_idle_pct = IDLE_PCT;
                recv_idle_pct = IDLE_PCT;
            end
            send_random_request();
        end
        wait_results_drained();
    endtask

    // Hold off the receiver while requests keep coming, so the output
    // register fills and the block stalls its input.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        hold_req_seq++;
        for (int i = 0; i < PRESSURE_REQS; i++) begin
            send_random_request();
        end
        send_idle_pct = IDLE_PCT;
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_edges();
        test_fill_to_capacity();
        test_random_requests();
        test_output_backpressure();

        // Let any stray result surface before judging.
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            n_errors++;
            $display("%0t: %0d results never arrived, expected 0, actual %0d",
                     $time, pending_results.size(), pending_results.size());
        end

        $display("Checked %0d results for %0d requests: inserted %0d, present %0d, full %0d,",
                 n_checked, n_sent, status_tally[STAT_INSERTED], status_tally[STAT_PRESENT],
                 status_tally[STAT_FULL]);
        $display("found %0d, absent %0d, removed %0d; table filled and drained, output held off",
                 status_tally[STAT_FOUND], status_tally[STAT_ABSENT],
                 status_tally[STAT_REMOVED]);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Hang guard, far beyond the slowest correct run.
    initial begin
        #(RUN_LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule
